FILE: hdl/bspe_pkg.sv
// Shared types and constants for the B-spline point evaluator.
// Used by the register block, controller, datapath and top level.
`timescale 1ns / 1ps
package bspe_pkg;

   localparam int MAX_ORDER  = 4;
   localparam int KNOT_COUNT = 9;
   // effective order cap: no knot beyond the knot vector is ever read
   localparam int ORDER_CAP  = (MAX_ORDER < KNOT_COUNT / 2) ? MAX_ORDER : KNOT_COUNT / 2;
   localparam int NB_DEPTH   = 2 * ORDER_CAP - 1;

   localparam int NB_AW      = 3;
   localparam int KSEL_W     = 4;
   localparam int BASIS_W    = 22;
   localparam int DIV_STEPS  = 36;
   localparam int DIV_CNT_W  = 6;

   localparam logic signed [BASIS_W-1:0] BASIS_ONE = 22'sd65536;
   localparam logic signed [BASIS_W-1:0] BASIS_MAX = 22'sd1048576;
   localparam logic signed [BASIS_W-1:0] BASIS_MIN = -22'sd1048576;

   localparam logic signed [27:0] OUT_MAX = 28'sh7FFFFFF;
   localparam logic signed [27:0] OUT_MIN = 28'sh8000000;

   typedef enum logic [2:0] {
      CSR_ORDER    = 3'd0,
      CSR_KNOTS_A  = 3'd1,
      CSR_KNOTS_B  = 3'd2,
      CSR_KNOTS_C  = 3'd3,
      CSR_POINTS_A = 3'd4,
      CSR_POINTS_B = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [2:0]  curve_order;
      logic [47:0] knots_a;
      logic [47:0] knots_b;
      logic [47:0] knots_c;
      logic [63:0] points_a;
      logic [63:0] points_b;
   } cfg_type;

   typedef struct packed {
      logic              load_t;
      logic [KSEL_W-1:0] knot_sel;
      logic [NB_AW-1:0]  nb_raddr;
      logic [NB_AW-1:0]  nb_waddr;
      logic [1:0]        pt_sel;
      logic              latch_ka;
      logic              box_wr;
      logic              latch_kq;
      logic              set_nd;
      logic              term_b;
      logic              mul;
      logic              div_start;
      logic              term_a_done;
      logic              term_b_done;
      logic              clr_acc;
      logic              pmul;
      logic              pacc;
      logic              out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_free;
   } status_type;

endpackage

FILE: hdl/bspline_point_eval.sv
// B-spline point evaluator, Cox-de Boor basis triangle on one divider.
// Items are processed one at a time: a new item is taken only when the previous
// one has left the sequencer. The 36-step radix-2 divider runs twice per blend
// node, once for each of its two terms.
// Reset (synchronous, high) restores order 3 with zero knots and points and
// empties the result register.
`timescale 1ns / 1ps
module bspline_point_eval (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_param_t,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [27:0] rsp_point_x,
   output logic signed [27:0] rsp_point_y,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data
);
   import bspe_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   bspe_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bspe_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .curve_order (cfg.curve_order),
      .status      (status),
      .cmd         (cmd)
   );

   bspe_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cfg         (cfg),
      .req_param_t (req_param_t),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_point_x (rsp_point_x),
      .rsp_point_y (rsp_point_y)
   );

endmodule

FILE: hdl/bspe_regs.sv
// Configuration register file for the B-spline point evaluator.
// Depends on bspe_pkg.
`timescale 1ns / 1ps
module bspe_regs (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_data,
   output bspe_pkg::cfg_type cfg
);
   import bspe_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.curve_order <= 3'd3;
         cfg_ff.knots_a     <= '0;
         cfg_ff.knots_b     <= '0;
         cfg_ff.knots_c     <= '0;
         cfg_ff.points_a    <= '0;
         cfg_ff.points_b    <= '0;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_ORDER:    cfg_ff.curve_order <= csr_data[2:0];
            CSR_KNOTS_A:  cfg_ff.knots_a     <= csr_data[47:0];
            CSR_KNOTS_B:  cfg_ff.knots_b     <= csr_data[47:0];
            CSR_KNOTS_C:  cfg_ff.knots_c     <= csr_data[47:0];
            CSR_POINTS_A: cfg_ff.points_a    <= csr_data;
            CSR_POINTS_B: cfg_ff.points_b    <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

FILE: hdl/bspe_ctrl.sv
// Sequencer for the B-spline point evaluator: box level, blend levels,
// weighted point sum. Depends on bspe_pkg.
`timescale 1ns / 1ps
module bspe_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          curve_order,
   input  bspe_pkg::status_type status,
   output bspe_pkg::cmd_type   cmd
);
   import bspe_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_BOX_K0, ST_BOX_K1, ST_BOX_W,
      ST_TQ, ST_TR, ST_TSET, ST_TMUL, ST_TLOAD, ST_TDIV, ST_TEND,
      ST_PRD, ST_PMUL, ST_PACC, ST_FIN
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] i_ff, i_in;
   logic [2:0] lvl_ff, lvl_in;
   logic [2:0] ord_ff, ord_in;
   logic       tb_ff, tb_in;
   logic [2:0] ord_eff;
   logic [3:0] box_last, lvl_last;

   always_comb begin
      ord_eff = curve_order;
      if (ord_eff == 3'd0) ord_eff = 3'd1;
      if (ord_eff > 3'(ORDER_CAP)) ord_eff = 3'(ORDER_CAP);
   end

   assign box_last  = {ord_ff, 1'b0} - 4'd2;
   assign lvl_last  = {ord_ff, 1'b0} - {1'b0, lvl_ff} - 4'd1;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      lvl_in   = lvl_ff;
      ord_in   = ord_ff;
      tb_in    = tb_ff;
      cmd      = '0;
      cmd.term_b   = tb_ff;
      cmd.nb_waddr = i_ff;
      cmd.pt_sel   = i_ff[1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_t = 1'b1;
               ord_in     = ord_eff;
               i_in       = '0;
               state_in   = ST_BOX_K0;
            end
         end
         ST_BOX_K0: begin
            cmd.knot_sel = {1'b0, i_ff};
            state_in     = ST_BOX_K1;
         end
         ST_BOX_K1: begin
            cmd.latch_ka = 1'b1;
            cmd.knot_sel = {1'b0, i_ff} + 4'd1;
            state_in     = ST_BOX_W;
         end
         ST_BOX_W: begin
            cmd.box_wr = 1'b1;
            if ({1'b0, i_ff} == box_last) begin
               i_in  = '0;
               tb_in = 1'b0;
               if (ord_ff == 3'd1) begin
                  cmd.clr_acc = 1'b1;
                  state_in    = ST_PRD;
               end else begin
                  lvl_in   = 3'd2;
                  state_in = ST_TQ;
               end
            end else begin
               i_in     = i_ff + 3'd1;
               state_in = ST_BOX_K0;
            end
         end
         ST_TQ: begin
            // term a: q = i+lvl-1, lower = nb[i]; term b: q = i+lvl, lower = nb[i+1]
            cmd.knot_sel = {1'b0, i_ff} + {1'b0, lvl_ff} - (tb_ff ? 4'd0 : 4'd1);
            cmd.nb_raddr = i_ff + (tb_ff ? 3'd1 : 3'd0);
            state_in     = ST_TR;
         end
         ST_TR: begin
            cmd.latch_kq = 1'b1;
            cmd.knot_sel = {1'b0, i_ff} + (tb_ff ? 4'd1 : 4'd0);
            state_in     = ST_TSET;
         end
         ST_TSET: begin
            cmd.set_nd = 1'b1;
            state_in   = ST_TMUL;
         end
         ST_TMUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_TLOAD;
         end
         ST_TLOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_TDIV;
         end
         ST_TDIV: begin
            if (status.div_done) state_in = ST_TEND;
         end
         ST_TEND: begin
            state_in = ST_TQ;
            if (!tb_ff) begin
               cmd.term_a_done = 1'b1;
               tb_in           = 1'b1;
            end else begin
               cmd.term_b_done = 1'b1;
               tb_in           = 1'b0;
               if ({1'b0, i_ff} == lvl_last) begin
                  i_in = '0;
                  if (lvl_ff == ord_ff) begin
                     cmd.clr_acc = 1'b1;
                     state_in    = ST_PRD;
                  end else begin
                     lvl_in = lvl_ff + 3'd1;
                  end
               end else begin
                  i_in = i_ff + 3'd1;
               end
            end
         end
         ST_PRD: begin
            cmd.nb_raddr = i_ff;
            state_in     = ST_PMUL;
         end
         ST_PMUL: begin
            cmd.pmul = 1'b1;
            state_in = ST_PACC;
         end
         ST_PACC: begin
            cmd.pacc = 1'b1;
            if (i_ff == ord_ff - 3'd1) begin
               state_in = ST_FIN;
            end else begin
               i_in     = i_ff + 3'd1;
               state_in = ST_PRD;
            end
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         lvl_ff   <= 3'd2;
         ord_ff   <= 3'd1;
         tb_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         lvl_ff   <= lvl_in;
         ord_ff   <= ord_in;
         tb_ff    <= tb_in;
      end
   end

endmodule

FILE: hdl/bspe_dp.sv
// Datapath: knot and point selection, basis store, blend multiplier,
// radix-2 divider, point accumulators and output register. Depends on bspe_pkg.
`timescale 1ns / 1ps
module bspe_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  bspe_pkg::cmd_type    cmd,
   input  bspe_pkg::cfg_type    cfg,
   input  logic [15:0]          req_param_t,
   output bspe_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [27:0]   rsp_point_x,
   output logic signed [27:0]   rsp_point_y
);
   import bspe_pkg::*;

   logic [15:0]               t_ff, kreg_ff, ka_ff, kq_ff, knot_val;
   logic signed [BASIS_W-1:0] nb_mem [NB_DEPTH];
   logic signed [BASIS_W-1:0] rd_ff, low_ff, wdata, clamped;
   logic signed [16:0]        num_ff, den_ff, num_in, den_in;
   logic signed [38:0]        prod_ff, prod_abs, sum;
   logic signed [16:0]        den_abs;
   logic [35:0]               dvd_ff;
   logic [15:0]               rem_ff, dvs_ff;
   logic [DIV_CNT_W-1:0]      cnt_ff;
   logic                      neg_ff, zero_ff;
   logic [16:0]               trial;
   logic                      ge;
   logic signed [37:0]        qmag, qs, acc_ff, mx_ff, my_ff;
   logic signed [15:0]        px_ff, py_ff, px_val, py_val;
   logic signed [39:0]        sx_ff, sy_ff, shx, shy;
   logic                      rsp_valid_ff;
   logic signed [27:0]        ox_ff, oy_ff, ox_in, oy_in;

   always_comb begin
      case (cmd.knot_sel)
         4'd0: knot_val = cfg.knots_a[15:0];
         4'd1: knot_val = cfg.knots_a[31:16];
         4'd2: knot_val = cfg.knots_a[47:32];
         4'd3: knot_val = cfg.knots_b[15:0];
         4'd4: knot_val = cfg.knots_b[31:16];
         4'd5: knot_val = cfg.knots_b[47:32];
         4'd6: knot_val = cfg.knots_c[15:0];
         4'd7: knot_val = cfg.knots_c[31:16];
         4'd8: knot_val = cfg.knots_c[47:32];
         default: knot_val = '0;
      endcase
      case (cmd.pt_sel)
         2'd0: begin px_val = cfg.points_a[15:0];  py_val = cfg.points_a[31:16]; end
         2'd1: begin px_val = cfg.points_a[47:32]; py_val = cfg.points_a[63:48]; end
         2'd2: begin px_val = cfg.points_b[15:0];  py_val = cfg.points_b[31:16]; end
         default: begin px_val = cfg.points_b[47:32]; py_val = cfg.points_b[63:48]; end
      endcase
   end

   // blend numerator and knot-difference denominator
   always_comb begin
      num_in = cmd.term_b ? ($signed({1'b0, kq_ff}) - $signed({1'b0, t_ff}))
                          : ($signed({1'b0, t_ff}) - $signed({1'b0, kreg_ff}));
      den_in = $signed({1'b0, kq_ff}) - $signed({1'b0, kreg_ff});
   end

   assign prod_abs = prod_ff[38] ? -prod_ff : prod_ff;
   assign den_abs  = den_ff[16] ? -den_ff : den_ff;
   assign trial    = {rem_ff, dvd_ff[35]};
   assign ge       = trial >= {1'b0, dvs_ff};
   assign qmag     = $signed({2'b00, dvd_ff});
   assign qs       = zero_ff ? 38'sd0 : (neg_ff ? -qmag : qmag);
   assign sum      = 39'(acc_ff) + 39'(qs);

   always_comb begin
      if (sum > 39'(BASIS_MAX))      clamped = BASIS_MAX;
      else if (sum < 39'(BASIS_MIN)) clamped = BASIS_MIN;
      else                           clamped = sum[BASIS_W-1:0];
      wdata = cmd.box_wr ? ((t_ff >= ka_ff && t_ff < kreg_ff) ? BASIS_ONE : '0) : clamped;
   end

   always_ff @(posedge clock) begin
      if (cmd.box_wr || cmd.term_b_done) nb_mem[cmd.nb_waddr] <= wdata;
      rd_ff <= nb_mem[cmd.nb_raddr];
   end

   always_ff @(posedge clock) begin
      kreg_ff <= knot_val;
      px_ff   <= px_val;
      py_ff   <= py_val;
      if (cmd.load_t)      t_ff   <= req_param_t;
      if (cmd.latch_ka)    ka_ff  <= kreg_ff;
      if (cmd.latch_kq) begin
         kq_ff  <= kreg_ff;
         low_ff <= rd_ff;
      end
      if (cmd.set_nd) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
      if (cmd.mul)         prod_ff <= 39'(num_ff) * 39'(low_ff);
      if (cmd.term_a_done) acc_ff  <= qs;
      if (cmd.pmul) begin
         mx_ff <= 38'(px_ff) * 38'(rd_ff);
         my_ff <= 38'(py_ff) * 38'(rd_ff);
      end
      if (cmd.clr_acc) begin
         sx_ff <= '0;
         sy_ff <= '0;
      end else if (cmd.pacc) begin
         sx_ff <= sx_ff + 40'(mx_ff);
         sy_ff <= sy_ff + 40'(my_ff);
      end
   end

   // restoring divider, one quotient bit per cycle; quotient shifts into dvd
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_start) begin
         cnt_ff  <= DIV_CNT_W'(DIV_STEPS);
         dvd_ff  <= prod_abs[35:0];
         dvs_ff  <= den_abs[15:0];
         rem_ff  <= '0;
         neg_ff  <= prod_ff[38] ^ den_ff[16];
         zero_ff <= (den_ff == 17'sd0);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
         rem_ff <= ge ? 16'(trial - {1'b0, dvs_ff}) : trial[15:0];
         dvd_ff <= {dvd_ff[34:0], ge};
      end
   end

   assign shx = sx_ff >>> 4;
   assign shy = sy_ff >>> 4;

   always_comb begin
      if (shx > 40'(OUT_MAX))      ox_in = OUT_MAX;
      else if (shx < 40'(OUT_MIN)) ox_in = OUT_MIN;
      else                         ox_in = shx[27:0];
      if (shy > 40'(OUT_MAX))      oy_in = OUT_MAX;
      else if (shy < 40'(OUT_MIN)) oy_in = OUT_MIN;
      else                         oy_in = shy[27:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         ox_ff <= ox_in;
         oy_ff <= oy_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = ox_ff;
   assign rsp_point_y     = oy_ff;
   assign status.div_done = (cnt_ff == '0);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

FILE: hdl/bspe_checker.sv
// Port-level checks for the B-spline point evaluator, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps
module bspe_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [27:0] rsp_point_x,
   input logic signed [27:0] rsp_point_y,
   input logic               csr_ready
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_point_x) && $stable(rsp_point_y))
      else $error("result beat changed under stall");

   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid out of reset");

   // one item in flight: busy right after an accepted beat
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while an item is in flight");

   // no result rises immediately after an item is accepted
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared right after accept");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("configuration port not ready");

endmodule

bind bspline_point_eval bspe_checker u_bspe_checker (.*);
